/* src/bba_pkg.sv */
// ----------------------------------------------------------------------------
// bba_pkg
// shared types, codes and helpers for the buddy block allocator
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int ORDER_LIMIT_DEF = 10;
  localparam int POOL_ORDER_RST  = 10;
  localparam int OP_W            = 1;
  localparam int SIZE_W          = 11;
  localparam int OFF_W           = 10;
  localparam int ORD_W           = 4;
  localparam int CFG_W           = 4;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NO_SPACE  = 2'd1,
    STAT_NOT_ALLOC = 2'd2,
    STAT_ZERO_SIZE = 2'd3
  } status_t;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  localparam logic [1:0] MK_UNUSED = 2'd0;
  localparam logic [1:0] MK_FREE   = 2'd1;
  localparam logic [1:0] MK_SPLIT  = 2'd2;
  localparam logic [1:0] MK_ALLOC  = 2'd3;

  // smallest k with 2^k >= size
  function automatic logic [3:0] size_order(input logic [SIZE_W-1:0] size);
    logic [3:0] k;
    k = 4'd11;
    for (int i = 11; i >= 0; i--) begin
      if ((12'd1 << i) >= {1'b0, size}) k = 4'(i);
    end
    return k;
  endfunction

endpackage

/* src/bba_if.sv */
// ----------------------------------------------------------------------------
// bba_req_if / bba_rsp_if
// valid/ready channels for allocator requests and results
// ----------------------------------------------------------------------------
interface bba_req_if import bba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [SIZE_W-1:0] request_size;
  logic [OFF_W-1:0]  free_offset;

  modport source (output valid, operation, request_size, free_offset, input ready);
  modport sink   (input valid, operation, request_size, free_offset, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [OFF_W-1:0] block_offset;
  logic [ORD_W-1:0] block_order;

  modport source (output valid, status, block_offset, block_order, input ready);
  modport sink   (input valid, status, block_offset, block_order, output ready);
endinterface

/* src/bba_mem.sv */
// ----------------------------------------------------------------------------
// bba_mem
// node store: one write port, two registered read ports
// ----------------------------------------------------------------------------
module bba_mem #(
  parameter int ADDR_W = 11,
  parameter int DATA_W = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] wa,
  input  logic [DATA_W-1:0] wd,
  input  logic [ADDR_W-1:0] ra_a,
  input  logic [ADDR_W-1:0] ra_b,
  output logic [DATA_W-1:0] rd_a,
  output logic [DATA_W-1:0] rd_b
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_a <= mem[ra_a];
    rd_b <= mem[ra_b];
  end

endmodule

/* src/bba_ctrl.sv */
// ----------------------------------------------------------------------------
// bba_ctrl
// sequencer: clearing sweep, descent for allocate and free, upward settle
// ----------------------------------------------------------------------------
module bba_ctrl import bba_pkg::*; #(
  parameter int ORDER_LIMIT = ORDER_LIMIT_DEF,
  parameter int NW          = ORDER_LIMIT + 1,
  parameter int OW          = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_wdata,
  bba_req_if.sink           req,
  bba_rsp_if.source         rsp,
  output logic              mem_we,
  output logic [NW-1:0]     mem_wa,
  output logic [OW+1:0]     mem_wd,
  output logic [NW-1:0]     mem_ra_a,
  output logic [NW-1:0]     mem_ra_b,
  input  logic [OW+1:0]     mem_rd_a,
  input  logic [OW+1:0]     mem_rd_b
);

  localparam int AW = ORDER_LIMIT;
  localparam logic [OW-1:0] POOL_RST =
    OW'((POOL_ORDER_RST > ORDER_LIMIT) ? ORDER_LIMIT : POOL_ORDER_RST);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_A_RD, S_A_EV, S_A_SPL_L, S_A_SPL_R,
    S_F_RD, S_F_EV, S_UP_RD, S_UP_EV, S_UP_WR, S_UP_WN, S_FIN
  } state_t;

  state_t          state;
  logic [NW-1:0]   cnt;
  logic [OW-1:0]   pool_order;
  logic [NW-1:0]   n;
  logic [OW-1:0]   o;
  logic [OW-1:0]   k;
  logic [AW-1:0]   start;
  logic [AW-1:0]   off_r;
  status_t         res_status;
  logic [OFF_W-1:0] res_off;
  logic [ORD_W-1:0] res_ord;

  logic [1:0]    m_a, m_b;
  logic [OW-1:0] b_a, b_b;
  logic [NW-1:0] n_l, n_r;
  logic [OW-1:0] kp1, o_dn;
  logic [AW-1:0] half;
  logic [OW-1:0] size_k;
  logic [CFG_W-1:0] cfg_sat;

  assign m_a  = mem_rd_a[OW+1:OW];
  assign b_a  = mem_rd_a[OW-1:0];
  assign m_b  = mem_rd_b[OW+1:OW];
  assign b_b  = mem_rd_b[OW-1:0];
  assign n_l  = {n[NW-2:0], 1'b0};
  assign n_r  = {n[NW-2:0], 1'b1};
  assign kp1  = k + OW'(1);
  assign o_dn = o - OW'(1);
  assign half = AW'(1) << o_dn;
  assign size_k  = OW'(size_order(req.request_size));
  assign cfg_sat = (int'(cfg_wdata) > ORDER_LIMIT) ? CFG_W'(ORDER_LIMIT) : cfg_wdata;

  assign req.ready = (state == S_IDLE);

  // memory port drive
  always_comb begin
    mem_we   = 1'b0;
    mem_wa   = n;
    mem_wd   = '0;
    mem_ra_a = n;
    mem_ra_b = n_l;
    unique case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = cnt;
        mem_wd = (cnt == NW'(1)) ? {MK_FREE, pool_order + OW'(1)} : '0;
      end
      S_A_EV: begin
        if (!((n == NW'(1)) && (b_a < kp1))) begin
          if (m_a == MK_FREE && o == k) begin
            mem_we = 1'b1;
            mem_wd = {MK_ALLOC, OW'(0)};
          end else if (!(o <= k || (m_a != MK_FREE && m_a != MK_SPLIT))
                       && m_a == MK_FREE) begin
            mem_we = 1'b1;
            mem_wd = {MK_SPLIT, b_a};
          end
        end
      end
      S_A_SPL_L: begin
        mem_we = 1'b1;
        mem_wa = n_l;
        mem_wd = {MK_FREE, o};
      end
      S_A_SPL_R: begin
        mem_we = 1'b1;
        mem_wa = n_r;
        mem_wd = {MK_FREE, o};
      end
      S_F_EV: begin
        if (m_a == MK_ALLOC && start == off_r) begin
          mem_we = 1'b1;
          mem_wd = {MK_FREE, o + OW'(1)};
        end
      end
      S_UP_RD: begin
        // siblings of the current node
        mem_ra_a = {n[NW-1:1], 1'b0};
        mem_ra_b = {n[NW-1:1], 1'b1};
      end
      S_UP_EV: begin
        mem_we = 1'b1;
        if (m_a == MK_FREE && m_b == MK_FREE) begin
          mem_wa = n_l;
          mem_wd = '0;
        end else begin
          mem_wd = {MK_SPLIT, (b_a > b_b) ? b_a : b_b};
        end
      end
      S_UP_WR: begin
        mem_we = 1'b1;
        mem_wa = n_r;
        mem_wd = '0;
      end
      S_UP_WN: begin
        mem_we = 1'b1;
        mem_wd = {MK_FREE, o + OW'(1)};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      cnt        <= '0;
      pool_order <= POOL_RST;
      rsp.valid  <= 1'b0;
    end else begin
      // in FIN without a config write the beat hand-off below owns valid
      if (rsp.valid && rsp.ready && (cfg_we || state != S_FIN)) rsp.valid <= 1'b0;
      if (cfg_we) begin
        pool_order <= OW'(cfg_sat);
        state      <= S_CLEAR;
        cnt        <= '0;
      end else begin
        unique case (state)
          S_CLEAR: begin
            cnt <= cnt + NW'(1);
            if (&cnt) state <= S_IDLE;
          end
          S_IDLE: begin
            n       <= NW'(1);
            o       <= pool_order;
            start   <= '0;
            k       <= size_k;
            off_r   <= AW'(req.free_offset);
            res_off <= '0;
            res_ord <= '0;
            if (req.valid) begin
              if (op_t'(req.operation) == OP_ALLOC) begin
                if (req.request_size == '0) begin
                  res_status <= STAT_ZERO_SIZE;
                  state      <= S_FIN;
                end else if (size_k > pool_order) begin
                  res_status <= STAT_NO_SPACE;
                  state      <= S_FIN;
                end else begin
                  state <= S_A_RD;
                end
              end else begin
                if ({22'd0, req.free_offset} >= (32'd1 << pool_order)) begin
                  res_status <= STAT_NOT_ALLOC;
                  state      <= S_FIN;
                end else begin
                  state <= S_F_RD;
                end
              end
            end
          end
          S_A_RD: state <= S_A_EV;
          S_A_EV: begin
            if ((n == NW'(1)) && (b_a < kp1)) begin
              res_status <= STAT_NO_SPACE;
              state      <= S_FIN;
            end else if (m_a == MK_FREE && o == k) begin
              res_status <= STAT_OK;
              res_off    <= OFF_W'(start);
              res_ord    <= ORD_W'(o);
              state      <= S_UP_RD;
            end else if (o <= k || (m_a != MK_FREE && m_a != MK_SPLIT)) begin
              res_status <= STAT_NO_SPACE;
              state      <= S_FIN;
            end else if (m_a == MK_FREE) begin
              state <= S_A_SPL_L;
            end else begin
              // split node: go left if the left subtree can hold it
              o <= o_dn;
              if (b_b >= kp1) begin
                n <= n_l;
              end else begin
                n     <= n_r;
                start <= start | half;
              end
              state <= S_A_RD;
            end
          end
          S_A_SPL_L: state <= S_A_SPL_R;
          S_A_SPL_R: begin
            n     <= n_l;
            o     <= o_dn;
            state <= S_A_RD;
          end
          S_F_RD: state <= S_F_EV;
          S_F_EV: begin
            if (m_a == MK_ALLOC) begin
              if (start != off_r) begin
                res_status <= STAT_NOT_ALLOC;
                state      <= S_FIN;
              end else begin
                res_status <= STAT_OK;
                res_off    <= OFF_W'(start);
                res_ord    <= ORD_W'(o);
                state      <= S_UP_RD;
              end
            end else if (m_a != MK_SPLIT || o == '0) begin
              res_status <= STAT_NOT_ALLOC;
              state      <= S_FIN;
            end else begin
              o <= o_dn;
              if (((off_r >> o_dn) & AW'(1)) != '0) begin
                n     <= n_r;
                start <= start | half;
              end else begin
                n <= n_l;
              end
              state <= S_F_RD;
            end
          end
          S_UP_RD: begin
            if (n == NW'(1)) begin
              state <= S_FIN;
            end else begin
              n     <= n >> 1;
              o     <= o + OW'(1);
              state <= S_UP_EV;
            end
          end
          S_UP_EV: begin
            if (m_a == MK_FREE && m_b == MK_FREE) state <= S_UP_WR;
            else state <= S_UP_RD;
          end
          S_UP_WR: state <= S_UP_WN;
          S_UP_WN: state <= S_UP_RD;
          S_FIN: begin
            if (!rsp.valid || rsp.ready) begin
              rsp.valid        <= 1'b1;
              rsp.status       <= res_status;
              rsp.block_offset <= res_off;
              rsp.block_order  <= res_ord;
              state            <= S_IDLE;
            end
          end
          default: state <= S_CLEAR;
        endcase
      end
    end
  end

endmodule

/* src/buddy_block_allocator.sv */
// ----------------------------------------------------------------------------
// buddy_block_allocator
// binary buddy allocator over a pool of 2^pool_order units
// ----------------------------------------------------------------------------
// a request rejected on its size or offset goes straight to its result beat;
//   otherwise the sequencer walks down the tree level by level and then settles
//   back up; one request at a time, set by the single node store and its write port
// reset and every pool_order write run a clearing sweep over all 2^(ORDER_LIMIT+1)
//   node entries, during which no request is taken
module buddy_block_allocator import bba_pkg::*; #(
  parameter int ORDER_LIMIT = ORDER_LIMIT_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  bba_req_if.sink          req,
  bba_rsp_if.source        rsp
);

  localparam int NW     = ORDER_LIMIT + 1;
  localparam int OW_RAW = $clog2(ORDER_LIMIT + 2);
  localparam int OW     = (OW_RAW < 4) ? 4 : OW_RAW;

  logic          mem_we;
  logic [NW-1:0] mem_wa, mem_ra_a, mem_ra_b;
  logic [OW+1:0] mem_wd, mem_rd_a, mem_rd_b;

  bba_ctrl #(.ORDER_LIMIT(ORDER_LIMIT), .NW(NW), .OW(OW)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .req      (req),
    .rsp      (rsp),
    .mem_we   (mem_we),
    .mem_wa   (mem_wa),
    .mem_wd   (mem_wd),
    .mem_ra_a (mem_ra_a),
    .mem_ra_b (mem_ra_b),
    .mem_rd_a (mem_rd_a),
    .mem_rd_b (mem_rd_b)
  );

  bba_mem #(.ADDR_W(NW), .DATA_W(OW + 2)) u_mem (
    .clk (clk),
    .we  (mem_we),
    .wa  (mem_wa),
    .wd  (mem_wd),
    .ra_a(mem_ra_a),
    .ra_b(mem_ra_b),
    .rd_a(mem_rd_a),
    .rd_b(mem_rd_b)
  );

endmodule

/* tb/sv/tb_buddy_block_allocator.sv */
// ----------------------------------------------------------------------------
// tb_buddy_block_allocator
// self-checking bench: a directed table at reset pool size, then random
// allocate and free traffic over several pool orders (including the
// saturating one), checked beat by beat against a behavioural buddy tree
// ----------------------------------------------------------------------------
module tb_buddy_block_allocator;
  import bba_pkg::*;

  localparam int NODES     = 2048;
  localparam int CYC_LIMIT = 3000000;
  localparam int SETTLE    = 200;

  typedef struct packed {
    status_t          status;
    logic [OFF_W-1:0] offset;
    logic [ORD_W-1:0] order;
  } alloc_result_t;

  typedef struct packed {
    op_t               op;
    logic [SIZE_W-1:0] size;
    logic [OFF_W-1:0]  offset;
    logic              typed;
    alloc_result_t     result;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  bba_req_if req ();
  bba_rsp_if rsp ();

  buddy_block_allocator u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .req(req), .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // buddy tree shadow
  logic [1:0]  tree_mark [NODES];
  logic [3:0]  tree_best [NODES];
  int unsigned pool_ord;
  int          live_offsets [$];
  alloc_result_t pending_results [$];

  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 29;
  int recv_idle_pct = 53;
  int n_ok = 0, n_nospace = 0, n_notalloc = 0, n_zero = 0;

  function automatic void clear_tree();
    for (int i = 0; i < NODES; i++) begin
      tree_mark[i] = MK_UNUSED;
      tree_best[i] = '0;
    end
    tree_mark[1] = MK_FREE;
    tree_best[1] = 4'(pool_ord + 1);
    live_offsets.delete();
  endfunction

  function automatic void merge_up(int unsigned n, int unsigned o);
    int unsigned l;
    while (n > 1) begin
      n = n >> 1;
      o++;
      l = 2 * n;
      if (tree_mark[l] == MK_FREE && tree_mark[l+1] == MK_FREE) begin
        tree_mark[l] = MK_UNUSED;
        tree_mark[l+1] = MK_UNUSED;
        tree_best[l] = '0;
        tree_best[l+1] = '0;
        tree_mark[n] = MK_FREE;
        tree_best[n] = 4'(o + 1);
      end else begin
        tree_best[n] = (tree_best[l] > tree_best[l+1]) ? tree_best[l] : tree_best[l+1];
      end
    end
  endfunction

  function automatic alloc_result_t take_block(int unsigned size);
    alloc_result_t r;
    int unsigned k, n, o, start;
    r = '{STAT_NO_SPACE, '0, '0};
    k = 0; n = 1; o = pool_ord; start = 0;
    if (size == 0) begin
      r.status = STAT_ZERO_SIZE;
      return r;
    end
    while (k < 12 && (1 << k) < size) k++;
    if (k > pool_ord || tree_best[1] < k + 1) return r;
    forever begin
      if (tree_mark[n] == MK_FREE && o == k) begin
        tree_mark[n] = MK_ALLOC;
        tree_best[n] = '0;
        merge_up(n, o);
        r = '{STAT_OK, OFF_W'(start), ORD_W'(o)};
        live_offsets.push_back(start);
        return r;
      end
      if (o <= k || (tree_mark[n] != MK_FREE && tree_mark[n] != MK_SPLIT)) return r;
      if (tree_mark[n] == MK_FREE) begin
        tree_mark[n] = MK_SPLIT;
        tree_mark[2*n] = MK_FREE;
        tree_mark[2*n+1] = MK_FREE;
        tree_best[2*n] = 4'(o);
        tree_best[2*n+1] = 4'(o);
      end
      o--;
      if (tree_best[2*n] >= k + 1) n = 2 * n;
      else begin
        n = 2 * n + 1;
        start += 1 << o;
      end
    end
  endfunction

  function automatic alloc_result_t release_block(int unsigned offset);
    alloc_result_t r;
    int unsigned n, o, start;
    r = '{STAT_NOT_ALLOC, '0, '0};
    n = 1; o = pool_ord; start = 0;
    if (offset >= (1 << pool_ord)) return r;
    forever begin
      if (tree_mark[n] == MK_ALLOC) begin
        if (start != offset) return r;
        tree_mark[n] = MK_FREE;
        tree_best[n] = 4'(o + 1);
        merge_up(n, o);
        foreach (live_offsets[i]) if (live_offsets[i] == offset) begin
          live_offsets.delete(i);
          break;
        end
        r = '{STAT_OK, OFF_W'(start), ORD_W'(o)};
        return r;
      end
      if (tree_mark[n] != MK_SPLIT || o == 0) return r;
      o--;
      if (offset >= start + (1 << o)) begin
        start += 1 << o;
        n = 2 * n + 1;
      end else n = 2 * n;
    end
  endfunction

  // drive one request beat; the shadow tree is updated when it is taken
  task automatic send(op_t op, int unsigned size, int unsigned offset, logic typed,
                      alloc_result_t typed_res);
    alloc_result_t r;
    if ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(negedge clk);
    end
    req.valid <= 1'b1;
    req.operation <= op;
    req.request_size <= SIZE_W'(size);
    req.free_offset <= OFF_W'(offset);
    do @(posedge clk); while (!req.ready);
    r = (op == OP_ALLOC) ? take_block(size) : release_block(offset);
    pending_results.push_back(typed ? typed_res : r);
    @(negedge clk);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_pool_order(int unsigned v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= CFG_W'(v);
    @(negedge clk);
    cfg_we <= 1'b0;
    pool_ord = (v > ORDER_LIMIT_DEF) ? ORDER_LIMIT_DEF : v;
    clear_tree();
  endtask

  task automatic random_traffic(int count);
    int unsigned pick, sz, off, top;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      top = 1 << pool_ord;
      if (pick < 3) begin
        // hold off until the pipe is empty
        drain();
      end
      if (pick < 50) begin
        sz = $urandom_range(3) == 0 ? $urandom_range(top, 1)
                                    : $urandom_range((top > 8) ? top / 8 : top, 1);
        send(OP_ALLOC, sz, 0, 1'b0, '0);
      end else if (pick < 55) begin
        sz = $urandom_range(1) ? 0 : $urandom_range(2047, top);
        send(OP_ALLOC, sz, 0, 1'b0, '0);
      end else if (pick < 85 && live_offsets.size() != 0) begin
        off = live_offsets[$urandom_range(live_offsets.size() - 1)];
        send(OP_FREE, $urandom_range(2047), off, 1'b0, '0);
      end else begin
        off = $urandom_range(1) ? $urandom_range(top - 1) : $urandom_range(1023);
        send(OP_FREE, $urandom_range(2047), off, 1'b0, '0);
      end
    end
  endtask

  dir_row_t dir_tab [18];

  // result checker
  always @(negedge clk) begin
    rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    alloc_result_t want;
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat status=%0d", $time, rsp.status);
        errors++;
      end else begin
        want = pending_results.pop_front();
        case (want.status)
          STAT_OK:        n_ok++;
          STAT_NO_SPACE:  n_nospace++;
          STAT_NOT_ALLOC: n_notalloc++;
          default:        n_zero++;
        endcase
        if (rsp.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, rsp.status);
          errors++;
        end
        if (rsp.block_offset !== want.offset) begin
          $display("%0t: block_offset expected %0d got %0d", $time, want.offset,
                   rsp.block_offset);
          errors++;
        end
        if (rsp.block_order !== want.order) begin
          $display("%0t: block_order expected %0d got %0d", $time, want.order,
                   rsp.block_order);
          errors++;
        end
      end
    end
  end

  initial begin
    int unsigned orders [8];
    req.valid = 1'b0;
    req.operation = OP_ALLOC;
    req.request_size = '0;
    req.free_offset = '0;
    rsp.ready = 1'b0;
    orders = '{0, 15, 3, 10, 7, 1, 5, 10};
    dir_tab = '{
      '{OP_ALLOC, 11'd0,    10'd0,    1'b1, '{STAT_ZERO_SIZE, 10'd0, 4'd0}},
      '{OP_ALLOC, 11'd2047, 10'd0,    1'b1, '{STAT_NO_SPACE, 10'd0, 4'd0}},
      '{OP_ALLOC, 11'd1025, 10'd0,    1'b1, '{STAT_NO_SPACE, 10'd0, 4'd0}},
      '{OP_ALLOC, 11'd1024, 10'd0,    1'b1, '{STAT_OK, 10'd0, 4'd10}},
      '{OP_ALLOC, 11'd1,    10'd0,    1'b1, '{STAT_NO_SPACE, 10'd0, 4'd0}},
      '{OP_FREE,  11'd0,    10'd1,    1'b1, '{STAT_NOT_ALLOC, 10'd0, 4'd0}},
      '{OP_FREE,  11'd2047, 10'd0,    1'b1, '{STAT_OK, 10'd0, 4'd10}},
      '{OP_FREE,  11'd0,    10'd0,    1'b1, '{STAT_NOT_ALLOC, 10'd0, 4'd0}},
      '{OP_ALLOC, 11'd1,    10'd0,    1'b1, '{STAT_OK, 10'd0, 4'd0}},
      '{OP_ALLOC, 11'd3,    10'd0,    1'b1, '{STAT_OK, 10'd4, 4'd2}},
      '{OP_ALLOC, 11'd2,    10'd0,    1'b1, '{STAT_OK, 10'd2, 4'd1}},
      '{OP_ALLOC, 11'd1,    10'd0,    1'b1, '{STAT_OK, 10'd1, 4'd0}},
      '{OP_FREE,  11'd0,    10'd5,    1'b1, '{STAT_NOT_ALLOC, 10'd0, 4'd0}},
      '{OP_FREE,  11'd0,    10'd1023, 1'b1, '{STAT_NOT_ALLOC, 10'd0, 4'd0}},
      '{OP_ALLOC, 11'd512,  10'd0,    1'b0, '0},
      '{OP_FREE,  11'd0,    10'd4,    1'b0, '0},
      '{OP_FREE,  11'd0,    10'd0,    1'b0, '0},
      '{OP_ALLOC, 11'd1000, 10'd0,    1'b0, '0}
    };
    pool_ord = POOL_ORDER_RST;
    clear_tree();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i])
      send(dir_tab[i].op, dir_tab[i].size, dir_tab[i].offset, dir_tab[i].typed,
           dir_tab[i].result);
    random_traffic(260);

    foreach (orders[p]) begin
      if (p == 0) begin
        send_idle_pct = 29;
        recv_idle_pct = 53;
      end else if (p == 3) begin
        send_idle_pct = 53;
        recv_idle_pct = 29;
      end else if (p == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_pool_order(orders[p]);
      if (pool_ord == 0) begin
        // a one-unit pool: any non-zero offset lies outside it
        send(OP_FREE, 0, 1, 1'b1, '{STAT_NOT_ALLOC, 10'd0, 4'd0});
        send(OP_ALLOC, 2, 0, 1'b1, '{STAT_NO_SPACE, 10'd0, 4'd0});
      end
      random_traffic((pool_ord < 2) ? 60 : 200);
    end

    drain();
    $display("covered %0d ok, %0d no-space, %0d not-allocated, %0d zero-size results",
             n_ok, n_nospace, n_notalloc, n_zero);
    $display("over pool orders 10, 0, 1, 3, 5, 7 and a saturating write");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
